// ===== rtl/dnsw_pkg.sv =====
// Package for the DNS message walker: phase codes, result kinds and the result record.
// Depends on nothing.
package dnsw_pkg;
    typedef enum logic [4:0] {
        PH_HEADER = 5'b00001,
        PH_NAME   = 5'b00010,
        PH_FIXED  = 5'b00100,
        PH_RDATA  = 5'b01000,
        PH_DONE   = 5'b10000
    } t_phase;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_RECORD = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;
    localparam logic [7:0] PTR_MASK    = 8'hC0;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  section;
        logic [15:0] msg_id;
        logic [15:0] msg_flags;
        logic [15:0] record_type;
        logic [15:0] record_class;
        logic [31:0] ttl;
        logic [15:0] data_length;
        logic [15:0] name_start;
        logic [15:0] data_start;
        logic        status;
        logic        last;
    } t_result;
endpackage

// ===== rtl/dnsw_if.sv =====
// Valid/ready channel interfaces for input bytes and results.
// Depends on dnsw_pkg.
interface dnsw_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_message;
    modport source (output valid, data_byte, end_of_message, input ready);
    modport sink (input valid, data_byte, end_of_message, output ready);
endinterface

interface dnsw_out_if import dnsw_pkg::*; ;
    logic    valid;
    logic    ready;
    t_result res;
    modport source (output valid, res, input ready);
    modport sink (input valid, res, output ready);
endinterface

// ===== rtl/dnsw_front.sv =====
// Front part: walks the message one byte per cycle while i_step is high and produces up to two results per byte.
// Depends on dnsw_pkg.
module dnsw_front import dnsw_pkg::*; #(
    parameter int MAX_MESSAGE_BYTES = 65535
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    input  logic       i_eom,
    output logic [1:0] o_count,
    output t_result    o_res0,
    output t_result    o_res1
);
    localparam logic [16:0] MaxB = 17'(MAX_MESSAGE_BYTES);

    t_phase      r_phase, n_phase;
    logic [15:0] r_off, n_off;
    logic [31:0] r_acc, n_acc;
    logic [3:0]  r_fbi, n_fbi;
    logic [7:0]  r_lab, n_lab;
    logic        r_ptr, n_ptr;
    logic [1:0]  r_sec, n_sec;
    logic [15:0] r_cnt [4];
    logic [15:0] n_cnt [4];
    logic [15:0] r_type, n_type, r_cls, n_cls, r_rdl, n_rdl;
    logic [15:0] r_nst, n_nst, r_id, n_id, r_flg, n_flg;
    logic [31:0] r_ttl, n_ttl;

    always_comb begin
        t_result rec, endr;
        logic    emit;
        logic [15:0] dlen, dst;
        logic    found;
        n_phase = r_phase; n_off = r_off; n_acc = r_acc; n_fbi = r_fbi;
        n_lab = r_lab; n_ptr = r_ptr; n_sec = r_sec; n_cnt = r_cnt;
        n_type = r_type; n_cls = r_cls; n_rdl = r_rdl; n_nst = r_nst;
        n_id = r_id; n_flg = r_flg; n_ttl = r_ttl;
        rec = '0; endr = '0; emit = 1'b0; dlen = '0; dst = '0; found = 1'b0;
        o_count = 2'd0; o_res0 = '0; o_res1 = '0;
        if ({1'b0, r_off} < MaxB) begin
            unique case (r_phase)
                PH_HEADER: begin
                    n_acc = {16'd0, r_acc[7:0], i_byte};
                    if (r_off[0]) begin
                        if (r_off == 16'd1) n_id = n_acc[15:0];
                        else if (r_off == 16'd3) n_flg = n_acc[15:0];
                        else n_cnt[2'(r_off[15:1] - 15'd2)] = n_acc[15:0];
                    end
                    if (r_off >= 16'd11) begin
                        rec = '0;
                        rec.kind = KIND_HEADER;
                        rec.msg_id = n_id;
                        rec.msg_flags = n_flg;
                        o_res0 = rec;
                        o_count = 2'd1;
                        n_acc = '0;
                        emit = 1'b1;
                    end
                end
                PH_NAME: begin
                    if (r_ptr) begin
                        n_ptr = 1'b0; n_phase = PH_FIXED; n_fbi = '0; n_acc = '0;
                    end else if (r_lab != 8'd0) begin
                        n_lab = r_lab - 8'd1;
                    end else if (i_byte == 8'd0) begin
                        n_phase = PH_FIXED; n_fbi = '0; n_acc = '0;
                    end else if ((i_byte & PTR_MASK) == PTR_MASK) begin
                        n_ptr = 1'b1;
                    end else begin
                        n_lab = i_byte;
                    end
                end
                PH_FIXED: begin
                    n_acc = {r_acc[23:0], i_byte};
                    n_fbi = r_fbi + 4'd1;
                    if (r_fbi == 4'd1) n_type = n_acc[15:0];
                    else if (r_fbi == 4'd3) begin
                        n_cls = n_acc[15:0];
                        if (r_sec == 2'd0) begin
                            n_ttl = '0; emit = 1'b1; n_fbi = r_fbi;
                        end
                    end else if (r_fbi == 4'd7) n_ttl = n_acc;
                    else if (r_fbi >= 4'd9) begin
                        n_fbi = r_fbi;
                        if (n_acc[15:0] == 16'd0) begin
                            emit = 1'b1; dst = r_off + 16'd1;
                        end else begin
                            n_acc = {16'd0, n_acc[15:0]};
                            n_rdl = n_acc[15:0];
                            n_phase = PH_RDATA;
                        end
                    end
                end
                PH_RDATA: begin
                    n_rdl = r_rdl - 16'd1;
                    if (n_rdl == 16'd0) begin
                        emit = 1'b1; dlen = r_acc[15:0];
                        dst = r_off + 16'd1 - dlen;
                    end
                end
                default: ;
            endcase
            if (emit && r_phase != PH_HEADER) begin
                rec = '0;
                rec.kind = KIND_RECORD;
                rec.section = r_sec;
                rec.record_type = n_type;
                rec.record_class = n_cls;
                if (r_sec != 2'd0) begin
                    rec.ttl = n_ttl; rec.data_length = dlen; rec.data_start = dst;
                end
                rec.name_start = r_nst;
                o_res0 = rec;
                o_count = 2'd1;
                n_cnt[r_sec] = r_cnt[r_sec] - 16'd1;
            end
            if (emit) begin
                n_phase = PH_DONE;
                for (int s = 0; s < 4; s++) begin
                    if (!found && (r_phase == PH_HEADER || s >= int'(r_sec))
                        && n_cnt[s] != 16'd0) begin
                        found = 1'b1;
                        n_sec = 2'(s); n_phase = PH_NAME; n_lab = '0; n_ptr = 1'b0;
                        n_fbi = '0; n_acc = '0; n_nst = r_off + 16'd1;
                    end
                end
            end
            n_off = r_off + 16'd1;
        end
        if (i_eom) begin
            endr = '0;
            endr.kind = KIND_END;
            endr.status = (n_phase != PH_DONE);
            endr.last = 1'b1;
            if (o_count == 2'd1) begin
                o_res1 = endr; o_count = 2'd2;
            end else begin
                o_res0 = endr; o_count = 2'd1;
            end
        end else if (o_count == 2'd1) begin
            o_res0.last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_eom)) begin
            r_phase <= PH_HEADER; r_off <= '0; r_acc <= '0; r_fbi <= '0; r_lab <= '0;
            r_ptr <= 1'b0; r_sec <= '0; r_type <= '0; r_cls <= '0; r_rdl <= '0;
            r_nst <= '0; r_id <= '0; r_flg <= '0; r_ttl <= '0;
            for (int s = 0; s < 4; s++) r_cnt[s] <= '0;
        end else if (i_step) begin
            r_phase <= n_phase; r_off <= n_off; r_acc <= n_acc; r_fbi <= n_fbi;
            r_lab <= n_lab; r_ptr <= n_ptr; r_sec <= n_sec; r_type <= n_type;
            r_cls <= n_cls; r_rdl <= n_rdl; r_nst <= n_nst; r_id <= n_id;
            r_flg <= n_flg; r_ttl <= n_ttl; r_cnt <= n_cnt;
        end
    end
endmodule

// ===== rtl/dnsw_queue.sv =====
// Result queue between the front walker and the output port; takes up to two results a cycle.
// Depends on dnsw_pkg.
module dnsw_queue import dnsw_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [1:0] i_count,
    input  t_result    i_res0,
    input  t_result    i_res1,
    output logic       o_room,
    output logic       o_valid,
    input  logic       i_ready,
    output t_result    o_res
);
    t_result    r_mem [4];
    logic [1:0] r_rd, r_wr;
    logic [2:0] r_fill;
    logic       pop;

    assign pop = o_valid && i_ready;
    assign o_valid = (r_fill != 3'd0);
    assign o_res = r_mem[r_rd];
    assign o_room = (r_fill <= 3'd2);

    always_ff @(posedge i_clk) begin
        if (i_count != 2'd0) r_mem[r_wr] <= i_res0;
        if (i_count == 2'd2) r_mem[r_wr + 2'd1] <= i_res1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd <= '0; r_wr <= '0; r_fill <= '0;
        end else begin
            r_wr <= r_wr + i_count;
            r_rd <= r_rd + 2'(pop);
            r_fill <= r_fill + 3'(i_count) - 3'(pop);
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= 3'd4) else $error("queue overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_count != 2'd0) |-> o_room)
        else $error("write without room");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill == 3'd0 && i_count == 2'd0) |=> r_fill == 3'd0)
        else $error("fill grew without write");
endmodule

// ===== rtl/dns_message_walker.sv =====
// DNS message walker top level: byte walker front, result queue back.
// Output: a result is written into the result queue when its byte is accepted and is offered from there.
// Throughput: one byte per cycle while the four-entry result queue has room for two.
// Reset: synchronous active-low i_rst_n clears walker state and empties the queue.
// The end-of-message byte returns the walker to its reset state.
module dns_message_walker import dnsw_pkg::*; #(
    parameter int MAX_MESSAGE_BYTES = 65535
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dnsw_in_if.sink     i_in,
    dnsw_out_if.source  o_out
);
    logic [1:0] cnt, wcnt;
    t_result    res0, res1;
    logic       room, step;

    assign i_in.ready = room;
    assign step = i_in.valid && room;
    assign wcnt = step ? cnt : 2'd0;

    dnsw_front #(.MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_step(step),
        .i_byte(i_in.data_byte), .i_eom(i_in.end_of_message),
        .o_count(cnt), .o_res0(res0), .o_res1(res1)
    );

    dnsw_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_count(wcnt), .i_res0(res0),
        .i_res1(res1), .o_room(room), .o_valid(o_out.valid),
        .i_ready(o_out.ready), .o_res(o_out.res)
    );
endmodule
